FILE: src/bml_pkg.sv
// ----------------------------------------------------------------------------
// Binomial modulo prime package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bml_pkg;

    // Default width of the sieve index; the sieve covers 0 .. 2^N_BITS - 1.
    localparam int N_BITS_DEF = 16;
    // Width of the n and m fields.
    localparam int ARG_W      = 16;
    // Width of the residue field.
    localparam int RES_W      = 14;
    // The prime modulus.
    localparam int PRIME_MOD  = 10007;
    // Number of steps of the bit-serial modular multiplier.
    localparam int MUL_STEPS  = RES_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;     // write one entry of the clearing pass
        logic sv_init;    // start the sieve at i = 2
        logic sv_rd;      // read the map at i
        logic sv_next;    // advance i and its square
        logic sv_jinit;   // first multiple to mark is i*i
        logic sv_mark;    // mark j composite, step j by i
        logic load;       // latch n and m, reset p and the product
        logic q_rd;       // read the map at p
        logic q_next;     // advance to the next candidate p
        logic leg_init;   // load the three Legendre lanes and the base
        logic red_step;   // subtract the modulus from the base
        logic div_init;   // clear remainders and the bit counter
        logic div_step;   // one restoring division step on every lane
        logic div_acc;    // add the quotients into the counts
        logic pow_init;   // form the exponent from the counts
        logic mul_init;   // start a modular multiplication
        logic mul_step;   // one multiplier step
        logic mul_done;   // take the product, count the exponent down
        logic out_ok;     // register a good result
        logic out_bad;    // register a rejected result
    } bml_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic sv_over;
        logic map_bit;
        logic j_over;
        logic bad_in;
        logic p_over;
        logic b_big;
        logic a_small;
        logic div_last;
        logic e_zero;
        logic mul_last;
    } bml_stat_t;

endpackage

FILE: src/bml_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write port, registered read data, no reset on the contents.
// ----------------------------------------------------------------------------
module bml_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on request; the read data is registered every cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bml_dpath.sv
// ----------------------------------------------------------------------------
// Binomial modulo prime datapath
// Holds the composite map, the sieve and prime counters, three Legendre
// division lanes, the base reduction and a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
module bml_dpath
    import bml_pkg::*;
#(
    parameter int N_BITS = N_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bml_cmd_t         cmd,
    output bml_stat_t        stat,
    input  logic [ARG_W-1:0] n_value,
    input  logic [ARG_W-1:0] k_value,
    output logic [RES_W-1:0] residue,
    output logic             bad_args
);

    localparam int W   = N_BITS;
    localparam int BW  = (W > 15) ? W : 15;
    localparam int DCW = $clog2(W);
    localparam int MCW = $clog2(MUL_STEPS);

    // Sieve state.
    logic [W-1:0]       clr_reg, clr_next;
    logic [W-1:0]       i_reg, i_next;
    logic [W:0]         sq_reg, sq_next;
    logic [W:0]         j_reg, j_next;

    // Query state.
    logic [W-1:0]       n_reg, n_next;
    logic [W-1:0]       m_reg, m_next;
    logic [W:0]         p_reg, p_next;
    logic [RES_W-1:0]   prod_reg, prod_next;
    logic [W-1:0]       a_reg [3];
    logic [W-1:0]       a_next [3];
    logic [W-1:0]       rem_reg [3];
    logic [W-1:0]       rem_next [3];
    logic [W-1:0]       c_reg [3];
    logic [W-1:0]       c_next [3];
    logic [DCW-1:0]     dcnt_reg, dcnt_next;
    logic [BW-1:0]      b_reg, b_next;
    logic [W-1:0]       e_reg, e_next;
    logic [RES_W-1:0]   acc_reg, acc_next;
    logic [RES_W-1:0]   x_reg, x_next;
    logic [MCW-1:0]     mcnt_reg, mcnt_next;
    logic [RES_W-1:0]   residue_reg, residue_next;
    logic               bad_reg, bad_next;

    // Memory port.
    logic               ram_we;
    logic [W-1:0]       ram_addr;
    logic               ram_wdata;
    logic               ram_rdata;

    // Multiplier step values.
    logic [RES_W+1:0]   mul_t;
    logic [RES_W+1:0]   mul_r;

    bml_ram #(
        .WIDTH (1),
        .DEPTH (1 << W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Memory address and write selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = 1'b0;
        if (cmd.clr_wr)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = (clr_reg < W'(2));
        end
        else if (cmd.sv_mark)
        begin
            ram_we    = 1'b1;
            ram_addr  = j_reg[W-1:0];
            ram_wdata = 1'b1;
        end
        else if (cmd.sv_rd)
        begin
            ram_addr = i_reg;
        end
        else if (cmd.q_rd)
        begin
            ram_addr = p_reg[W-1:0];
        end
    end

    // One step of the interleaved modular multiplier: 2*acc + bit*b, reduced.
    always_comb
    begin
        mul_t = {1'b0, acc_reg, 1'b0}
              + (x_reg[RES_W-1] ? {2'b00, b_reg[RES_W-1:0]} : '0);
        if (mul_t >= (RES_W+2)'(2 * PRIME_MOD))
        begin
            mul_r = mul_t - (RES_W+2)'(2 * PRIME_MOD);
        end
        else if (mul_t >= (RES_W+2)'(PRIME_MOD))
        begin
            mul_r = mul_t - (RES_W+2)'(PRIME_MOD);
        end
        else
        begin
            mul_r = mul_t;
        end
    end

    // Next values of every register under the controller's commands.
    always_comb
    begin
        logic [W:0] sh;
        clr_next     = clr_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        m_next       = m_reg;
        p_next       = p_reg;
        prod_next    = prod_reg;
        a_next       = a_reg;
        rem_next     = rem_reg;
        c_next       = c_reg;
        dcnt_next    = dcnt_reg;
        b_next       = b_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        mcnt_next    = mcnt_reg;
        residue_next = residue_reg;
        bad_next     = bad_reg;
        sh           = '0;

        if (cmd.clr_wr)
        begin
            clr_next = clr_reg + W'(1);
        end
        if (cmd.sv_init)
        begin
            i_next  = W'(2);
            sq_next = (W+1)'(4);
        end
        if (cmd.sv_next)
        begin
            i_next  = i_reg + W'(1);
            sq_next = sq_reg + {i_reg, 1'b1};
        end
        if (cmd.sv_jinit)
        begin
            j_next = sq_reg;
        end
        if (cmd.sv_mark)
        begin
            j_next = j_reg + {1'b0, i_reg};
        end
        if (cmd.load)
        begin
            n_next    = W'(n_value);
            m_next    = W'(k_value);
            p_next    = (W+1)'(2);
            prod_next = RES_W'(1);
        end
        if (cmd.q_next)
        begin
            p_next = p_reg + (W+1)'(1);
        end
        if (cmd.leg_init)
        begin
            a_next[0] = n_reg;
            a_next[1] = m_reg;
            a_next[2] = n_reg - m_reg;
            for (int l = 0; l < 3; l++)
            begin
                c_next[l] = '0;
            end
            b_next = BW'(p_reg[W-1:0]);
        end
        if (cmd.red_step)
        begin
            b_next = b_reg - BW'(PRIME_MOD);
        end
        if (cmd.div_init)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_next[l] = '0;
            end
            dcnt_next = '0;
        end
        // Restoring division of each lane by p, one quotient bit a step.
        if (cmd.div_step)
        begin
            for (int l = 0; l < 3; l++)
            begin
                sh = {rem_reg[l], a_reg[l][W-1]};
                if (sh >= p_reg)
                begin
                    sh          = sh - p_reg;
                    a_next[l]   = {a_reg[l][W-2:0], 1'b1};
                end
                else
                begin
                    a_next[l]   = {a_reg[l][W-2:0], 1'b0};
                end
                rem_next[l] = sh[W-1:0];
            end
            dcnt_next = dcnt_reg + DCW'(1);
        end
        if (cmd.div_acc)
        begin
            for (int l = 0; l < 3; l++)
            begin
                c_next[l] = c_reg[l] + a_reg[l];
            end
        end
        if (cmd.pow_init)
        begin
            e_next = c_reg[0] - c_reg[1] - c_reg[2];
        end
        if (cmd.mul_init)
        begin
            acc_next  = '0;
            x_next    = prod_reg;
            mcnt_next = '0;
        end
        if (cmd.mul_step)
        begin
            acc_next  = mul_r[RES_W-1:0];
            x_next    = {x_reg[RES_W-2:0], 1'b0};
            mcnt_next = mcnt_reg + MCW'(1);
        end
        if (cmd.mul_done)
        begin
            prod_next = acc_reg;
            e_next    = e_reg - W'(1);
        end
        if (cmd.out_ok)
        begin
            residue_next = prod_reg;
            bad_next     = 1'b0;
        end
        if (cmd.out_bad)
        begin
            residue_next = '0;
            bad_next     = 1'b1;
        end
    end

    // The clearing counter is control state; the rest is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        sq_reg      <= sq_next;
        j_reg       <= j_next;
        n_reg       <= n_next;
        m_reg       <= m_next;
        p_reg       <= p_next;
        prod_reg    <= prod_next;
        a_reg       <= a_next;
        rem_reg     <= rem_next;
        c_reg       <= c_next;
        dcnt_reg    <= dcnt_next;
        b_reg       <= b_next;
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        x_reg       <= x_next;
        mcnt_reg    <= mcnt_next;
        residue_reg <= residue_next;
        bad_reg     <= bad_next;
    end

    // Status towards the controller.
    always_comb
    begin
        stat.clr_last = &clr_reg;
        stat.sv_over  = sq_reg[W];
        stat.map_bit  = ram_rdata;
        stat.j_over   = j_reg[W];
        stat.bad_in   = (k_value > n_value) || ((32'(n_value) >> W) != 32'd0);
        stat.p_over   = p_reg > {1'b0, n_reg};
        stat.b_big    = b_reg >= BW'(PRIME_MOD);
        stat.a_small  = {1'b0, a_reg[0]} < p_reg;
        stat.div_last = dcnt_reg == DCW'(W - 1);
        stat.e_zero   = e_reg == '0;
        stat.mul_last = mcnt_reg == MCW'(MUL_STEPS - 1);
    end

    assign residue  = residue_reg;
    assign bad_args = bad_reg;

endmodule

FILE: src/bml_ctrl.sv
// ----------------------------------------------------------------------------
// Binomial modulo prime controller
// Sequences the sieve after reset and then each query over the primes.
// ----------------------------------------------------------------------------
module bml_ctrl
    import bml_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bml_stat_t stat,
    output bml_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [3:0] {
        S_CLR,
        S_SV_CHK,
        S_SV_TEST,
        S_SV_MARK,
        S_IDLE,
        S_Q_CHK,
        S_Q_TEST,
        S_RED,
        S_DIV_CHK,
        S_DIV,
        S_DIV_ACC,
        S_POW,
        S_MUL,
        S_MUL_END
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done_next  = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.sv_init = 1'b1;
                    state_next  = S_SV_CHK;
                end
            end
            S_SV_CHK:
            begin
                if (stat.sv_over)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.sv_rd  = 1'b1;
                    state_next = S_SV_TEST;
                end
            end
            S_SV_TEST:
            begin
                if (stat.map_bit)
                begin
                    cmd.sv_next = 1'b1;
                    state_next  = S_SV_CHK;
                end
                else
                begin
                    cmd.sv_jinit = 1'b1;
                    state_next   = S_SV_MARK;
                end
            end
            S_SV_MARK:
            begin
                if (stat.j_over)
                begin
                    cmd.sv_next = 1'b1;
                    state_next  = S_SV_CHK;
                end
                else
                begin
                    cmd.sv_mark = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (stat.bad_in)
                    begin
                        cmd.out_bad = 1'b1;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = S_Q_CHK;
                    end
                end
            end
            S_Q_CHK:
            begin
                if (stat.p_over)
                begin
                    cmd.out_ok = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_Q_TEST;
                end
            end
            S_Q_TEST:
            begin
                if (stat.map_bit)
                begin
                    cmd.q_next = 1'b1;
                    state_next = S_Q_CHK;
                end
                else
                begin
                    cmd.leg_init = 1'b1;
                    state_next   = S_RED;
                end
            end
            S_RED:
            begin
                if (stat.b_big)
                begin
                    cmd.red_step = 1'b1;
                end
                else
                begin
                    state_next = S_DIV_CHK;
                end
            end
            S_DIV_CHK:
            begin
                if (stat.a_small)
                begin
                    cmd.pow_init = 1'b1;
                    state_next   = S_POW;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DIV_ACC;
                end
            end
            S_DIV_ACC:
            begin
                cmd.div_acc = 1'b1;
                state_next  = S_DIV_CHK;
            end
            S_POW:
            begin
                if (stat.e_zero)
                begin
                    cmd.q_next = 1'b1;
                    state_next = S_Q_CHK;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = S_MUL_END;
                end
            end
            S_MUL_END:
            begin
                cmd.mul_done = 1'b1;
                state_next   = S_POW;
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: src/binomial_mod_prime_legendre_core.sv
// After reset the block is busy clearing the map and then running the sieve
// marking pass, both on the single map port.
// A query takes a data-dependent time: each candidate value up to n is read from
// the map, and each prime adds Legendre division rounds and modular multiplications.
// One query at a time; each result shows for one cycle with done and cannot be stalled.
// Reset is asynchronous and active low; it restarts the sieve.
// ----------------------------------------------------------------------------
// Binomial coefficient modulo 10007
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module binomial_mod_prime_legendre_core
    import bml_pkg::*;
#(
    parameter int N_BITS = N_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [ARG_W-1:0] n_value,
    input  logic [ARG_W-1:0] k_value,
    output logic             done,
    output logic [RES_W-1:0] residue,
    output logic             bad_args
);

    bml_cmd_t  cmd;
    bml_stat_t stat;

    // Sequencing of the sieve and the queries.
    bml_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Storage and arithmetic.
    bml_dpath #(
        .N_BITS (N_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .n_value  (n_value),
        .k_value  (k_value),
        .residue  (residue),
        .bad_args (bad_args)
    );

endmodule

FILE: bench/binomial_mod_prime_legendre_core_tb.sv
// ----------------------------------------------------------------------------
// Binomial modulo prime testbench
// Sends n and m queries through the start and busy handshake and compares
// every residue and error flag with a predictor that builds its own sieve
// and applies Legendre's formula prime by prime.
// ----------------------------------------------------------------------------
module binomial_mod_prime_legendre_core_tb;
    import bml_pkg::*;

    localparam int  MAP_DEPTH   = 1 << N_BITS_DEF;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct {
        logic [RES_W-1:0] residue;
        logic             bad_args;
    } binom_result_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [ARG_W-1:0] n_value;
    logic [ARG_W-1:0] k_value;
    logic             done;
    logic [RES_W-1:0] residue;
    logic             bad_args;

    bit               composite_bit [MAP_DEPTH];
    binom_result_t    pending_residues[$];
    int               fail_count;
    longint           cycle_count;

    binomial_mod_prime_legendre_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .n_value  (n_value),
        .k_value  (k_value),
        .done     (done),
        .residue  (residue),
        .bad_args (bad_args)
    );

    // Free-running clock with a period of four units.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Build the composite map once, exactly as the block's sieve does.
    task automatic build_sieve();
        longint i;
        longint j;
        for (i = 0; i < MAP_DEPTH; i++)
            composite_bit[i] = 1'b0;
        composite_bit[0] = 1'b1;
        composite_bit[1] = 1'b1;
        for (i = 2; i * i < MAP_DEPTH; i++)
        begin
            if (!composite_bit[i])
            begin
                for (j = i * i; j < MAP_DEPTH; j += i)
                    composite_bit[j] = 1'b1;
            end
        end
    endtask

    // Exponent of the prime p in x factorial.
    function automatic longint legendre_count(longint x, longint p);
        longint total;
        longint q;
        total = 0;
        q = p;
        while (q <= x)
        begin
            total += x / q;
            q *= p;
        end
        return total;
    endfunction

    // Expected result for one query.
    function automatic binom_result_t binom_residue(logic [ARG_W-1:0] n, logic [ARG_W-1:0] k);
        binom_result_t r;
        longint prod;
        longint acc;
        longint b;
        longint e;
        longint p;
        r.bad_args = 1'b0;
        r.residue  = '0;
        if (k > n)
        begin
            r.bad_args = 1'b1;
            return r;
        end
        prod = 1;
        for (p = 2; p <= n; p++)
        begin
            if (composite_bit[p])
                continue;
            e = legendre_count(n, p) - legendre_count(k, p) - legendre_count(n - k, p);
            acc = 1;
            b = p % PRIME_MOD;
            while (e != 0)
            begin
                if (e & 1)
                    acc = (acc * b) % PRIME_MOD;
                b = (b * b) % PRIME_MOD;
                e >>= 1;
            end
            prod = (prod * acc) % PRIME_MOD;
        end
        r.residue = prod[RES_W-1:0];
        return r;
    endfunction

    // One transfer of a query, after a random gap or none.
    // Start stays high after the transfer so that a query with no gap follows
    // directly; a gap or a drain lowers it.
    task automatic send_query(logic [ARG_W-1:0] n, logic [ARG_W-1:0] k);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        n_value <= n;
        k_value <= k;
        do
            @(posedge clk);
        while (busy);
        pending_residues = {pending_residues, binom_residue(n, k)};
    endtask

    // Hold the sender off until every expected result has come.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_residues.size() != 0)
            @(posedge clk);
    endtask

    // Field extremes, rejected arguments and the trivial cases.
    task automatic test_directed();
        send_query(16'd0, 16'd0);
        send_query(16'd0, 16'd1);
        send_query(16'd1, 16'd0);
        send_query(16'd1, 16'd1);
        send_query(16'd5, 16'd2);
        send_query(16'd10, 16'd10);
        send_query(16'd3, 16'hFFFF);
        send_query(16'd100, 16'd50);
        send_query(16'd200, 16'd7);
        send_query(16'd10006, 16'd3);
        send_query(16'd10007, 16'd1);
        send_query(16'd10010, 16'd5000);
        send_query(16'hFFFF, 16'hFFFF);
        send_query(16'd12, 16'd13);
        drain_results();
    endtask

    // Random queries, n up to 300 with mostly valid m, some rejected.
    task automatic test_random();
        logic [ARG_W-1:0] n;
        logic [ARG_W-1:0] k;
        int sel;
        for (int i = 0; i < 100; i++)
        begin
            sel = $urandom_range(0, 9);
            n = ARG_W'($urandom_range(0, 300));
            if (sel < 6)
                k = ARG_W'($urandom_range(0, n));
            else if (sel < 8)
                k = ARG_W'($urandom_range(0, n + 4));
            else
                k = ARG_W'($urandom);
            send_query(n, k);
            if (i == 50)
                drain_results();
        end
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        binom_result_t want;
        if (rst_n && done)
        begin
            if (pending_residues.size() == 0)
            begin
                $error("unexpected result: residue %0d bad_args %0d", residue, bad_args);
                fail_count++;
            end
            else
            begin
                want = pending_residues.pop_front();
                if (residue !== want.residue)
                begin
                    $error("residue: expected %0d, actual %0d", want.residue, residue);
                    fail_count++;
                end
                if (bad_args !== want.bad_args)
                begin
                    $error("bad_args: expected %0d, actual %0d", want.bad_args, bad_args);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("binomial_mod_prime_legendre_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        fail_count  = 0;
        cycle_count = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        n_value = '0;
        k_value = '0;
        build_sieve();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        drain_results();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_residues.size() == 0)
            $display("binomial_mod_prime_legendre_core: match");
        else
            $display("binomial_mod_prime_legendre_core: mismatch");
        $finish;
    end

endmodule
